// ===== hdl/jhip_pkg.sv =====
package jhip_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned FieldWidth  = 16;
   localparam int unsigned StatusWidth = 4;

   localparam logic [StatusWidth-1:0] ST_OK        = 4'd0;
   localparam logic [StatusWidth-1:0] ST_NO_SOI    = 4'd1;
   localparam logic [StatusWidth-1:0] ST_NO_MARKER = 4'd2;
   localparam logic [StatusWidth-1:0] ST_UNEXP     = 4'd3;
   localparam logic [StatusWidth-1:0] ST_SEG_LEN   = 4'd4;
   localparam logic [StatusWidth-1:0] ST_SOF_LEN   = 4'd5;
   localparam logic [StatusWidth-1:0] ST_PREC      = 4'd6;
   localparam logic [StatusWidth-1:0] ST_ZERO_H    = 4'd7;
   localparam logic [StatusWidth-1:0] ST_ZERO_W    = 4'd8;
   localparam logic [StatusWidth-1:0] ST_TRUNC     = 4'd9;

   localparam logic [ByteWidth-1:0] MARKER_PREFIX = 8'hFF;
   localparam logic [ByteWidth-1:0] MARKER_SOI    = 8'hD8;
   localparam logic [ByteWidth-1:0] MARKER_SOF0   = 8'hC0;
   localparam logic [ByteWidth-1:0] MARKER_SOF1   = 8'hC1;
   localparam logic [ByteWidth-1:0] MARKER_SOF2   = 8'hC2;
   localparam logic [ByteWidth-1:0] MARKER_SOF9   = 8'hC9;
   localparam logic [ByteWidth-1:0] MARKER_SOF10  = 8'hCA;
   localparam logic [ByteWidth-1:0] MARKER_DQT    = 8'hDB;
   localparam logic [ByteWidth-1:0] MARKER_APP0   = 8'hE0;
   localparam logic [ByteWidth-1:0] MARKER_APP15  = 8'hEF;
   localparam logic [ByteWidth-1:0] SAMPLE_PREC   = 8'd8;
   localparam logic [ByteWidth-1:0] ONE_COMPONENT = 8'd1;

   localparam logic [FieldWidth-1:0] MIN_SEG_LEN = 16'd2;
   localparam logic [FieldWidth-1:0] MIN_SOF_LEN = 16'd11;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 start_of_file;
      logic                 end_of_data;
   } req_item_type;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [FieldWidth-1:0]  pic_width;
      logic [FieldWidth-1:0]  pic_height;
      logic                   is_gray;
      logic [ByteWidth-1:0]   offending_marker;
   } rsp_item_type;

   typedef enum logic [11:0] {
      PH_SOI_FF    = 12'b0000_0000_0001,
      PH_SOI_CODE  = 12'b0000_0000_0010,
      PH_MARK_FF   = 12'b0000_0000_0100,
      PH_MARK_CODE = 12'b0000_0000_1000,
      PH_SEG_LEN   = 12'b0000_0001_0000,
      PH_SKIP      = 12'b0000_0010_0000,
      PH_SOF_LEN   = 12'b0000_0100_0000,
      PH_PREC      = 12'b0000_1000_0000,
      PH_HEIGHT    = 12'b0001_0000_0000,
      PH_WIDTH     = 12'b0010_0000_0000,
      PH_COMP      = 12'b0100_0000_0000,
      PH_DONE      = 12'b1000_0000_0000
   } phase_type;

endpackage

// ===== hdl/jhip_req_if.sv =====
interface jhip_req_if;
   logic                      valid;
   logic                      ready;
   logic [jhip_pkg::ByteWidth-1:0] data_byte;
   logic                      start_of_file;
   logic                      end_of_data;

   modport source (output valid, output data_byte, output start_of_file,
                   output end_of_data, input ready);
   modport sink (input valid, input data_byte, input start_of_file,
                 input end_of_data, output ready);
endinterface

// ===== hdl/jhip_rsp_if.sv =====
interface jhip_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [jhip_pkg::StatusWidth-1:0]   status;
   logic [jhip_pkg::FieldWidth-1:0]    pic_width;
   logic [jhip_pkg::FieldWidth-1:0]    pic_height;
   logic                               is_gray;
   logic [jhip_pkg::ByteWidth-1:0]     offending_marker;

   modport source (output valid, output status, output pic_width,
                   output pic_height, output is_gray, output offending_marker,
                   input ready);
   modport sink (input valid, input status, input pic_width,
                 input pic_height, input is_gray, input offending_marker,
                 output ready);
endinterface

// ===== hdl/jpeg_header_info_parser.sv =====
// JPEG header parser. Bytes of a file arrive one per beat on the req_bus
// channel, with start_of_file on the first byte and end_of_data on an extra
// beat that carries no byte. For each file exactly one beat leaves on the
// rsp_bus channel: a status, the frame width and height, a gray flag and,
// for an unexpected marker, its code. Bytes after that beat are ignored
// until the next start of file.
// The block accepts one byte per cycle while the receiver takes results.
// A byte is taken into the input register and then parsed into the output
// register, from which the result is offered on rsp_bus. The parse state
// is updated combinationally for every byte, which keeps the rate at one.
// Reset puts the parser at the start of a file, so the first file needs no
// start_of_file, and empties both registers. When the receiver holds off,
// the output register keeps its beat, at most one more byte is taken into
// the input register and then req_bus.ready stays low until the result is
// taken.
module jpeg_header_info_parser (
   input  logic       clock,
   input  logic       reset,
   jhip_req_if.sink   req_bus,
   jhip_rsp_if.source rsp_bus
);
   import jhip_pkg::*;

   logic         advance;
   logic         item_valid;
   req_item_type item;
   logic         res_valid;
   rsp_item_type res;

   jhip_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   jhip_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (item_valid && advance),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   jhip_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .advance   (advance),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== hdl/jhip_in_stage.sv =====
module jhip_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   jhip_req_if.sink               req_bus,
   input  logic                   advance,
   output logic                   item_valid,
   output jhip_pkg::req_item_type item
);
   import jhip_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         take;

   assign req_bus.ready = !valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      item_in  = item_ff;
      valid_in = valid_ff;
      if (take) begin
         item_in.data_byte     = req_bus.data_byte;
         item_in.start_of_file = req_bus.start_of_file;
         item_in.end_of_data   = req_bus.end_of_data;
         valid_in              = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hdl/jhip_parser.sv =====
module jhip_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  jhip_pkg::req_item_type item,
   output logic                   res_valid,
   output jhip_pkg::rsp_item_type res
);
   import jhip_pkg::*;

   phase_type              phase_ff, phase_in, ph;
   logic                   bof_ff, bof_in, bof;
   logic [ByteWidth-1:0]   seg_hi_ff, seg_hi_in;
   logic [FieldWidth-1:0]  skip_ff, skip_in;
   logic [FieldWidth-1:0]  height_ff, height_in;
   logic [FieldWidth-1:0]  width_ff, width_in;
   logic [ByteWidth-1:0]   b;
   logic [FieldWidth-1:0]  full_len;
   logic                   finish;
   logic [StatusWidth-1:0] fin_status;
   logic                   is_app;
   logic                   is_sof;

   assign b        = item.data_byte;
   assign full_len = {seg_hi_ff, b};
   assign is_app   = (b >= MARKER_APP0) && (b <= MARKER_APP15);
   assign is_sof   = (b == MARKER_SOF0) || (b == MARKER_SOF1) || (b == MARKER_SOF2) ||
                     (b == MARKER_SOF9) || (b == MARKER_SOF10);

   always_comb begin
      ph         = item.start_of_file ? PH_SOI_FF : phase_ff;
      bof        = item.start_of_file ? 1'b0 : bof_ff;
      phase_in   = ph;
      bof_in     = bof;
      seg_hi_in  = seg_hi_ff;
      skip_in    = skip_ff;
      height_in  = height_ff;
      width_in   = width_ff;
      finish     = 1'b0;
      fin_status = ST_OK;
      res        = '0;
      if (ph == PH_DONE) begin
         phase_in = PH_DONE;
      end else if (item.end_of_data) begin
         finish     = 1'b1;
         fin_status = ST_TRUNC;
      end else begin
         unique case (ph)
            PH_SOI_FF: begin
               if (b != MARKER_PREFIX) begin
                  finish     = 1'b1;
                  fin_status = ST_NO_SOI;
               end else begin
                  phase_in = PH_SOI_CODE;
               end
            end
            PH_SOI_CODE: begin
               if (b == MARKER_SOI) begin
                  phase_in = PH_MARK_FF;
               end else if (b != MARKER_PREFIX) begin
                  finish     = 1'b1;
                  fin_status = ST_NO_SOI;
               end
            end
            PH_MARK_FF: begin
               if (b != MARKER_PREFIX) begin
                  finish     = 1'b1;
                  fin_status = ST_NO_MARKER;
               end else begin
                  phase_in = PH_MARK_CODE;
               end
            end
            PH_MARK_CODE: begin
               if (b != MARKER_PREFIX) begin
                  bof_in = 1'b0;
                  if (is_app || b == MARKER_DQT) begin
                     phase_in = PH_SEG_LEN;
                  end else if (is_sof) begin
                     phase_in = PH_SOF_LEN;
                  end else begin
                     finish               = 1'b1;
                     fin_status           = ST_UNEXP;
                     res.offending_marker = b;
                  end
               end
            end
            PH_SEG_LEN: begin
               if (!bof) begin
                  seg_hi_in = b;
                  bof_in    = 1'b1;
               end else begin
                  bof_in = 1'b0;
                  if (full_len < MIN_SEG_LEN) begin
                     finish     = 1'b1;
                     fin_status = ST_SEG_LEN;
                  end else begin
                     skip_in  = full_len - MIN_SEG_LEN;
                     phase_in = (full_len == MIN_SEG_LEN) ? PH_MARK_FF : PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 16'd1;
               if (skip_ff == 16'd1) begin
                  phase_in = PH_MARK_FF;
               end
            end
            PH_SOF_LEN: begin
               if (!bof) begin
                  seg_hi_in = b;
                  bof_in    = 1'b1;
               end else begin
                  bof_in = 1'b0;
                  if (full_len < MIN_SOF_LEN) begin
                     finish     = 1'b1;
                     fin_status = ST_SOF_LEN;
                  end else begin
                     phase_in = PH_PREC;
                  end
               end
            end
            PH_PREC: begin
               if (b != SAMPLE_PREC) begin
                  finish     = 1'b1;
                  fin_status = ST_PREC;
               end else begin
                  phase_in = PH_HEIGHT;
               end
            end
            PH_HEIGHT: begin
               if (!bof) begin
                  height_in = {b, 8'h00};
                  bof_in    = 1'b1;
               end else begin
                  height_in = {height_ff[FieldWidth-1:ByteWidth], b};
                  bof_in    = 1'b0;
                  if (height_in == '0) begin
                     finish     = 1'b1;
                     fin_status = ST_ZERO_H;
                  end else begin
                     phase_in = PH_WIDTH;
                  end
               end
            end
            PH_WIDTH: begin
               if (!bof) begin
                  width_in = {b, 8'h00};
                  bof_in   = 1'b1;
               end else begin
                  width_in = {width_ff[FieldWidth-1:ByteWidth], b};
                  bof_in   = 1'b0;
                  if (width_in == '0) begin
                     finish     = 1'b1;
                     fin_status = ST_ZERO_W;
                  end else begin
                     phase_in = PH_COMP;
                  end
               end
            end
            PH_COMP: begin
               finish         = 1'b1;
               fin_status     = ST_OK;
               res.pic_width  = width_ff;
               res.pic_height = height_ff;
               res.is_gray    = (b == ONE_COMPONENT);
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
      if (finish) begin
         phase_in = PH_DONE;
      end
      res.status = fin_status;
   end

   assign res_valid = fire && finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SOI_FF;
         bof_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         bof_ff   <= bof_in;
      end
      if (fire) begin
         seg_hi_ff <= seg_hi_in;
         skip_ff   <= skip_in;
         height_ff <= height_in;
         width_ff  <= width_in;
      end
   end

   a_done_is_silent : assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_DONE && !item.start_of_file |-> !res_valid)
      else $error("Result produced after the file was already reported.");

   a_ok_has_size : assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status == ST_OK |-> res.pic_width != '0 && res.pic_height != '0)
      else $error("Successful result carries a zero dimension.");

   a_result_ends_file : assert property (@(posedge clock) disable iff (reset)
      res_valid |=> phase_ff == PH_DONE)
      else $error("Parser did not settle after reporting a result.");

   a_skip_nonzero : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_ff != '0)
      else $error("Skip phase entered with nothing left to skip.");

endmodule

// ===== hdl/jhip_out_stage.sv =====
module jhip_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   res_valid,
   input  jhip_pkg::rsp_item_type res,
   output logic                   advance,
   jhip_rsp_if.source             rsp_bus
);
   import jhip_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   assign advance = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (advance) begin
         valid_in = res_valid;
         item_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_bus.valid            = valid_ff;
   assign rsp_bus.status           = item_ff.status;
   assign rsp_bus.pic_width        = item_ff.pic_width;
   assign rsp_bus.pic_height       = item_ff.pic_height;
   assign rsp_bus.is_gray          = item_ff.is_gray;
   assign rsp_bus.offending_marker = item_ff.offending_marker;

endmodule
